// ===== rtl/ltbt_pkg.sv =====
// ----------------------------------------------------------------------------
// ltbt_pkg - light balance tracker shared definitions
// Types, register indexes, status codes and the sensor pair table used by the
// tracker top level and its compare unit.
// ----------------------------------------------------------------------------
package ltbt_pkg;

	localparam int NUM_SENSORS = 16;
	localparam int IDX_BITS    = 4;
	localparam int TOL_BITS    = 12;
	localparam int ANGLE_BITS  = 8;
	localparam int STEP_BITS   = 4;
	localparam int CFG_IDX_BITS = 2;

	typedef logic [IDX_BITS-1:0]   sensor_idx_t;
	typedef logic [STEP_BITS-1:0]  step_t;
	typedef logic [ANGLE_BITS-1:0] angle_t;
	typedef logic [TOL_BITS-1:0]   tol_t;
	typedef logic [1:0]            status_t;

	// Axis status codes
	localparam status_t ST_STEPPED  = 2'd0;
	localparam status_t ST_BALANCED = 2'd1;
	localparam status_t ST_LIMIT    = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_TOLERANCE   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_UPPER_LIMIT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LOWER_LIMIT = 2'd2;

	localparam tol_t   TOL_RESET   = 12'd205;
	localparam angle_t UPPER_RESET = 8'd130;
	localparam angle_t LOWER_RESET = 8'd50;
	localparam angle_t ANGLE_RESET = 8'd90;

	// Evaluation steps: five horizontal pairs, five vertical pairs, then
	// the two direction compares.
	localparam step_t STEP_VERT_FIRST = 4'd5;
	localparam step_t STEP_DIR_H      = 4'd10;
	localparam step_t STEP_DIR_V      = 4'd11;
	localparam step_t LAST_STEP       = STEP_DIR_V;

	typedef struct packed {
		logic near;
		logic a_gt_b;
		logic a_lt_b;
	} cmp_res_t;

	typedef enum logic [3:0] {
		FSM_IDLE  = 4'b0001,
		FSM_EVAL  = 4'b0010,
		FSM_DRAIN = 4'b0100,
		FSM_DONE  = 4'b1000
	} fsm_t;

	function automatic sensor_idx_t pair_a(input step_t s);
		sensor_idx_t r;
		unique case (s)
			4'd0:    r = 4'd0;
			4'd1:    r = 4'd5;
			4'd2:    r = 4'd6;
			4'd3:    r = 4'd7;
			4'd4:    r = 4'd8;
			4'd5:    r = 4'd0;
			4'd6:    r = 4'd1;
			4'd7:    r = 4'd2;
			4'd8:    r = 4'd3;
			4'd9:    r = 4'd4;
			4'd10:   r = 4'd6;
			4'd11:   r = 4'd2;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic sensor_idx_t pair_b(input step_t s);
		sensor_idx_t r;
		unique case (s)
			4'd0:    r = 4'd4;
			4'd1:    r = 4'd15;
			4'd2:    r = 4'd14;
			4'd3:    r = 4'd13;
			4'd4:    r = 4'd12;
			4'd5:    r = 4'd12;
			4'd6:    r = 4'd11;
			4'd7:    r = 4'd10;
			4'd8:    r = 4'd9;
			4'd9:    r = 4'd8;
			4'd10:   r = 4'd14;
			4'd11:   r = 4'd10;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/two_axis_light_balance_tracker_top.sv =====
// ----------------------------------------------------------------------------
// two_axis_light_balance_tracker_top - two axis light balance tracker
// Stores one light sample per sensor; on a scan end item checks balance of
// both axes through one shared compare unit and steps each unbalanced axis inside its limits.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  sample   | start, sensor_index, adc_level, scan_end; | in
//           | busy                                      | out
//  result   | done, horiz_status, vert_status,          | out
//           | horiz_angle, vert_angle, found            |
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// An item without scan end is stored in its accept cycle; busy stays low.
// A scan end item keeps busy high while its 12 pairs are read through the
// two read ports of the sample store, the compare register is drained and
// the angles are updated; done pulses in the cycle after.
// Reset clears control, presets the angles (90) and the config; the sample store
// is not cleared. The result receiver cannot stall; config is always ready.
// ----------------------------------------------------------------------------
module two_axis_light_balance_tracker_top #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [ltbt_pkg::IDX_BITS-1:0]      sensor_index,
	input  logic [SAMPLE_BITS-1:0]             adc_level,
	input  logic                               scan_end,
	output logic                               done,
	output logic [1:0]                         horiz_status,
	output logic [1:0]                         vert_status,
	output logic [ltbt_pkg::ANGLE_BITS-1:0]    horiz_angle,
	output logic [ltbt_pkg::ANGLE_BITS-1:0]    vert_angle,
	output logic                               found,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ltbt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [ltbt_pkg::TOL_BITS-1:0]      cfg_data
);

	ltbt_pkg::fsm_t     state_q;
	ltbt_pkg::step_t    cnt_q;
	ltbt_pkg::step_t    step_s1;
	logic               vld_s1;
	logic [SAMPLE_BITS-1:0] rd_a_s1;
	logic [SAMPLE_BITS-1:0] rd_b_s1;
	logic [SAMPLE_BITS-1:0] mem [ltbt_pkg::NUM_SENSORS];

	ltbt_pkg::tol_t     tol_q;
	ltbt_pkg::angle_t   upper_q;
	ltbt_pkg::angle_t   lower_q;
	ltbt_pkg::angle_t   h_angle_q;
	ltbt_pkg::angle_t   v_angle_q;
	logic               h_bal_q;
	logic               v_bal_q;
	logic               h_up_q;
	logic               v_up_q;
	logic               done_q;
	ltbt_pkg::status_t  h_status_q;
	ltbt_pkg::status_t  v_status_q;
	logic               found_q;

	ltbt_pkg::cmp_res_t cmp_res;
	logic               accept;
	ltbt_pkg::status_t  h_status_d;
	ltbt_pkg::status_t  v_status_d;
	ltbt_pkg::angle_t   h_angle_d;
	ltbt_pkg::angle_t   v_angle_d;

	assign busy      = (state_q != ltbt_pkg::FSM_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= ltbt_pkg::TOL_RESET;
			upper_q <= ltbt_pkg::UPPER_RESET;
			lower_q <= ltbt_pkg::LOWER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ltbt_pkg::CFG_TOLERANCE:   tol_q   <= cfg_data;
				ltbt_pkg::CFG_UPPER_LIMIT: upper_q <= cfg_data[ltbt_pkg::ANGLE_BITS-1:0];
				ltbt_pkg::CFG_LOWER_LIMIT: lower_q <= cfg_data[ltbt_pkg::ANGLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Sample store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (accept) begin
			mem[sensor_index] <= adc_level;
		end
		if (state_q == ltbt_pkg::FSM_EVAL) begin
			rd_a_s1 <= mem[ltbt_pkg::pair_a(cnt_q)];
			rd_b_s1 <= mem[ltbt_pkg::pair_b(cnt_q)];
		end
	end

	ltbt_cmp #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_cmp (
		.a   (rd_a_s1),
		.b   (rd_b_s1),
		.tol (tol_q),
		.res (cmp_res)
	);

	// Axis decision from the accumulated compare results
	always_comb begin
		h_angle_d = h_angle_q;
		v_angle_d = v_angle_q;
		if (h_bal_q) begin
			h_status_d = ltbt_pkg::ST_BALANCED;
		end else if (h_angle_q >= upper_q || h_angle_q <= lower_q) begin
			h_status_d = ltbt_pkg::ST_LIMIT;
		end else begin
			h_status_d = ltbt_pkg::ST_STEPPED;
			h_angle_d  = h_up_q ? h_angle_q + 8'd1 : h_angle_q - 8'd1;
		end
		if (v_bal_q) begin
			v_status_d = ltbt_pkg::ST_BALANCED;
		end else if (v_angle_q >= upper_q || v_angle_q <= lower_q) begin
			v_status_d = ltbt_pkg::ST_LIMIT;
		end else begin
			v_status_d = ltbt_pkg::ST_STEPPED;
			v_angle_d  = v_up_q ? v_angle_q + 8'd1 : v_angle_q - 8'd1;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ltbt_pkg::FSM_IDLE;
			cnt_q     <= '0;
			step_s1   <= '0;
			vld_s1    <= 1'b0;
			h_bal_q   <= 1'b1;
			v_bal_q   <= 1'b1;
			h_up_q    <= 1'b0;
			v_up_q    <= 1'b0;
			h_angle_q <= ltbt_pkg::ANGLE_RESET;
			v_angle_q <= ltbt_pkg::ANGLE_RESET;
			done_q    <= 1'b0;
			h_status_q <= ltbt_pkg::ST_STEPPED;
			v_status_q <= ltbt_pkg::ST_STEPPED;
			found_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= (state_q == ltbt_pkg::FSM_EVAL);
			step_s1 <= cnt_q;

			// fold the previous read pair into the axis flags
			if (vld_s1) begin
				priority if (step_s1 < ltbt_pkg::STEP_VERT_FIRST) begin
					h_bal_q <= h_bal_q && cmp_res.near;
				end else if (step_s1 < ltbt_pkg::STEP_DIR_H) begin
					v_bal_q <= v_bal_q && cmp_res.near;
				end else if (step_s1 == ltbt_pkg::STEP_DIR_H) begin
					h_up_q <= cmp_res.a_gt_b;
				end else begin
					v_up_q <= cmp_res.a_lt_b;
				end
			end

			unique case (state_q)
				ltbt_pkg::FSM_IDLE: begin
					if (accept && scan_end) begin
						cnt_q   <= '0;
						h_bal_q <= 1'b1;
						v_bal_q <= 1'b1;
						state_q <= ltbt_pkg::FSM_EVAL;
					end
				end
				ltbt_pkg::FSM_EVAL: begin
					if (cnt_q == ltbt_pkg::LAST_STEP) begin
						state_q <= ltbt_pkg::FSM_DRAIN;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				ltbt_pkg::FSM_DRAIN: begin
					state_q <= ltbt_pkg::FSM_DONE;
				end
				ltbt_pkg::FSM_DONE: begin
					h_angle_q  <= h_angle_d;
					v_angle_q  <= v_angle_d;
					h_status_q <= h_status_d;
					v_status_q <= v_status_d;
					found_q    <= (h_status_d != ltbt_pkg::ST_STEPPED)
						&& (v_status_d != ltbt_pkg::ST_STEPPED);
					done_q     <= 1'b1;
					state_q    <= ltbt_pkg::FSM_IDLE;
				end
				default: state_q <= ltbt_pkg::FSM_IDLE;
			endcase
		end
	end

	assign done         = done_q;
	assign horiz_status = h_status_q;
	assign vert_status  = v_status_q;
	assign horiz_angle  = h_angle_q;
	assign vert_angle   = v_angle_q;
	assign found        = found_q;

	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ltbt_pkg::FSM_DONE))
		else $error("result strobe without an angle update");

	a_found_matches: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (found_q == ((h_status_q != ltbt_pkg::ST_STEPPED)
			&& (v_status_q != ltbt_pkg::ST_STEPPED))))
		else $error("found flag disagrees with statuses");

	a_h_step_one: assert property (@(posedge clk) disable iff (!arst_n)
		(h_angle_q == $past(h_angle_q)) || (h_angle_q == $past(h_angle_q) + 8'd1)
		|| (h_angle_q == $past(h_angle_q) - 8'd1))
		else $error("horizontal angle moved by more than one degree");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ltbt_pkg::FSM_EVAL) |-> (cnt_q <= ltbt_pkg::LAST_STEP))
		else $error("step counter ran past the last pair");

	a_eval_feeds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ltbt_pkg::FSM_DRAIN) |-> (vld_s1 && step_s1 == ltbt_pkg::LAST_STEP))
		else $error("last compare not in flight at drain");

endmodule

// ===== rtl/ltbt_cmp.sv =====
// ----------------------------------------------------------------------------
// ltbt_cmp - shared level compare unit
// Subtracts b from a (and a from b when negative): absolute difference against
// the tolerance, plus the sign of the difference for the step direction.
// ----------------------------------------------------------------------------
module ltbt_cmp #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic [SAMPLE_BITS-1:0] a,
	input  logic [SAMPLE_BITS-1:0] b,
	input  ltbt_pkg::tol_t         tol,
	output ltbt_pkg::cmp_res_t     res
);

	localparam int CW = (SAMPLE_BITS > ltbt_pkg::TOL_BITS) ? SAMPLE_BITS
		: ltbt_pkg::TOL_BITS;

	logic [SAMPLE_BITS:0]   diff;
	logic [SAMPLE_BITS-1:0] abs_diff;
	logic [CW-1:0]          abs_ext;
	logic [CW-1:0]          tol_ext;

	assign diff     = {1'b0, a} - {1'b0, b};
	assign abs_diff = diff[SAMPLE_BITS] ? (b - a) : diff[SAMPLE_BITS-1:0];
	assign abs_ext  = CW'(abs_diff);
	assign tol_ext  = CW'(tol);

	assign res.near   = (abs_ext <= tol_ext);
	assign res.a_lt_b = diff[SAMPLE_BITS];
	assign res.a_gt_b = !diff[SAMPLE_BITS] && (diff[SAMPLE_BITS-1:0] != '0);

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - two axis light balance tracker
// Writes light samples through the start/busy port; checks each scan result
// against a behavioural tracker kept in step with every accepted item and
// register write, or against a scripted check's typed reading. Scripted
// corner cases precede randomised sweeps and bursts under changing settings.
// ----------------------------------------------------------------------------
module testbench;

	typedef logic [ltbt_pkg::CFG_IDX_BITS-1:0] reg_idx_t;
	typedef logic [11:0] level_t;

	localparam reg_idx_t CFG_UNUSED = 2'd3;
	localparam int RANDOM_SAMPLES = 1600;
	localparam int SETTLE_CYCLES  = 20;

	// Balance pairs, one sensor index per nibble
	localparam logic [19:0] H_FIRST  = {4'd0, 4'd5, 4'd6, 4'd7, 4'd8};
	localparam logic [19:0] H_SECOND = {4'd4, 4'd15, 4'd14, 4'd13, 4'd12};
	localparam logic [19:0] V_FIRST  = {4'd0, 4'd1, 4'd2, 4'd3, 4'd4};
	localparam logic [19:0] V_SECOND = {4'd12, 4'd11, 4'd10, 4'd9, 4'd8};

	typedef struct packed {
		ltbt_pkg::status_t hs;
		ltbt_pkg::status_t vs;
		ltbt_pkg::angle_t  ha;
		ltbt_pkg::angle_t  va;
		logic              fnd;
	} reading_t;

	typedef struct packed {
		ltbt_pkg::status_t st;
		ltbt_pkg::angle_t  ang;
	} axis_out_t;

	typedef struct packed {
		logic                  is_cfg;
		reg_idx_t              ci;
		ltbt_pkg::tol_t        cd;
		ltbt_pkg::sensor_idx_t s;
		level_t                lv;
		logic                  se;
		logic                  typed;
		reading_t              want;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	ltbt_pkg::sensor_idx_t sensor_index = '0;
	level_t                adc_level = '0;
	logic                  scan_end = 1'b0;
	logic                  done;
	logic [1:0]            horiz_status;
	logic [1:0]            vert_status;
	ltbt_pkg::angle_t      horiz_angle;
	ltbt_pkg::angle_t      vert_angle;
	logic                  found;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	reg_idx_t              cfg_index = '0;
	ltbt_pkg::tol_t        cfg_data = '0;

	// Typed reading travelling with the item on the port
	logic     row_typed = 1'b0;
	reading_t row_want = '0;

	// Tracker copy
	level_t           stored_lvl [16];
	ltbt_pkg::angle_t h_ang = ltbt_pkg::ANGLE_RESET;
	ltbt_pkg::angle_t v_ang = ltbt_pkg::ANGLE_RESET;
	ltbt_pkg::tol_t   tol_r = ltbt_pkg::TOL_RESET;
	ltbt_pkg::angle_t upper_r = ltbt_pkg::UPPER_RESET;
	ltbt_pkg::angle_t lower_r = ltbt_pkg::LOWER_RESET;

	reading_t  due_q [$];
	plan_row_t plan_q [$];

	bit no_gaps = 1'b0;
	int sent = 0;
	int samples_seen = 0;
	int readings_checked = 0;
	int reg_writes = 0;
	int mismatches = 0;
	int n_step = 0;
	int n_bal = 0;
	int n_lim = 0;
	int n_found = 0;

	two_axis_light_balance_tracker_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.sensor_index (sensor_index),
		.adc_level    (adc_level),
		.scan_end     (scan_end),
		.done         (done),
		.horiz_status (horiz_status),
		.vert_status  (vert_status),
		.horiz_angle  (horiz_angle),
		.vert_angle   (vert_angle),
		.found        (found),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic bit pairs_even(logic [19:0] first, logic [19:0] second);
		int k;
		int x;
		int y;
		for (k = 0; k < 5; k++) begin
			x = stored_lvl[first[k*4 +: 4]];
			y = stored_lvl[second[k*4 +: 4]];
			if ((x > y ? x - y : y - x) > int'(tol_r))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic axis_out_t move_axis(bit even, bit up, ltbt_pkg::angle_t ang);
		axis_out_t o;
		o.ang = ang;
		if (even)
			o.st = ltbt_pkg::ST_BALANCED;
		else if (ang >= upper_r || ang <= lower_r)
			o.st = ltbt_pkg::ST_LIMIT;
		else begin
			o.st = ltbt_pkg::ST_STEPPED;
			o.ang = up ? ang + 8'd1 : ang - 8'd1;
		end
		return o;
	endfunction

	// Evaluate both axes on the stored levels and advance the angles
	function automatic reading_t track_scan();
		axis_out_t h;
		axis_out_t v;
		reading_t r;
		h = move_axis(pairs_even(H_FIRST, H_SECOND), stored_lvl[6] > stored_lvl[14], h_ang);
		v = move_axis(pairs_even(V_FIRST, V_SECOND), stored_lvl[2] < stored_lvl[10], v_ang);
		h_ang = h.ang;
		v_ang = v.ang;
		r.hs = h.st;
		r.vs = v.st;
		r.ha = h.ang;
		r.va = v.ang;
		r.fnd = (h.st != ltbt_pkg::ST_STEPPED) && (v.st != ltbt_pkg::ST_STEPPED);
		return r;
	endfunction

	task automatic note_mismatch(string what, reading_t want, reading_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s at %0t: want h=%0d/%0d v=%0d/%0d found=%0b, got h=%0d/%0d v=%0d/%0d found=%0b",
				what, $time, want.hs, want.ha, want.vs, want.va, want.fnd,
				got.hs, got.ha, got.vs, got.va, got.fnd);
	endtask

	always @(posedge clk) begin : monitor
		reading_t got;
		reading_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				reg_writes++;
				case (cfg_index)
					ltbt_pkg::CFG_TOLERANCE:   tol_r = cfg_data;
					ltbt_pkg::CFG_UPPER_LIMIT: upper_r = cfg_data[7:0];
					ltbt_pkg::CFG_LOWER_LIMIT: lower_r = cfg_data[7:0];
					default: ;
				endcase
			end
			if (done) begin
				got.hs = horiz_status;
				got.vs = vert_status;
				got.ha = horiz_angle;
				got.va = vert_angle;
				got.fnd = found;
				if (due_q.size() == 0)
					note_mismatch("unexpected reading", '0, got);
				else begin
					want = due_q.pop_front();
					readings_checked++;
					if (got.hs !== want.hs || got.vs !== want.vs || got.ha !== want.ha ||
							got.va !== want.va || got.fnd !== want.fnd)
						note_mismatch("reading mismatch", want, got);
					n_step += (want.hs == ltbt_pkg::ST_STEPPED)
						+ (want.vs == ltbt_pkg::ST_STEPPED);
					n_bal += (want.hs == ltbt_pkg::ST_BALANCED)
						+ (want.vs == ltbt_pkg::ST_BALANCED);
					n_lim += (want.hs == ltbt_pkg::ST_LIMIT) + (want.vs == ltbt_pkg::ST_LIMIT);
					n_found += want.fnd;
				end
			end
			if (start && !busy) begin
				samples_seen++;
				stored_lvl[sensor_index] = adc_level;
				if (scan_end) begin
					want = track_scan();
					due_q.push_back(row_typed ? row_want : want);
				end
			end
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// Offer one item and hold it until the block takes it
	task automatic send_sample(ltbt_pkg::sensor_idx_t s, level_t lv, bit se, bit typed,
			reading_t want);
		int gap;
		gap = idle_len();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		sensor_index <= s;
		adc_level <= lv;
		scan_end <= se;
		row_typed <= typed;
		row_want <= want;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	// Drop start and let the block go idle before touching a register
	task automatic settle();
		start <= 1'b0;
		while (due_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t ci, ltbt_pkg::tol_t cd);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= ci;
		cfg_data <= cd;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic shuffle_config();
		int pick;
		int lo;
		int hi;
		pick = $urandom_range(0, 5);
		if (pick == 0)
			write_reg(ltbt_pkg::CFG_TOLERANCE, 12'd0);
		else if (pick == 1)
			write_reg(ltbt_pkg::CFG_TOLERANCE, 12'd4095);
		else if (pick == 2)
			write_reg(ltbt_pkg::CFG_TOLERANCE, 12'($urandom_range(0, 4095)));
		else if (pick != 5)
			write_reg(ltbt_pkg::CFG_TOLERANCE, 12'($urandom_range(1, 400)));
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			// crossed limits
			lo = $urandom_range(90, 180);
			hi = $urandom_range(0, lo);
		end else if (pick == 1) begin
			lo = $urandom_range(0, 4095);
			hi = $urandom_range(0, 4095);
		end else if (pick == 2) begin
			lo = 50;
			hi = 130;
		end else begin
			// keep the angles inside the window so they can step
			lo = (h_ang < v_ang ? h_ang : v_ang) - $urandom_range(1, 30);
			hi = (h_ang > v_ang ? h_ang : v_ang) + $urandom_range(1, 30);
			if (lo < 0)
				lo = 0;
			if (hi > 255)
				hi = 255;
		end
		if ($urandom_range(0, 3) != 0)
			write_reg(ltbt_pkg::CFG_UPPER_LIMIT, hi[11:0]);
		if ($urandom_range(0, 3) != 0)
			write_reg(ltbt_pkg::CFG_LOWER_LIMIT, lo[11:0]);
		if ($urandom_range(0, 9) == 0)
			write_reg(CFG_UNUSED, 12'($urandom_range(0, 4095)));
	endtask

	function automatic level_t pick_level(int base, int spread, int wild);
		int v;
		if ($urandom_range(0, 63) < wild)
			return level_t'($urandom_range(0, 4095));
		v = base + $urandom_range(0, 2 * spread) - spread;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v[11:0];
	endfunction

	function automatic int pick_base();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 0;
		if (r == 1)
			return 4095;
		return $urandom_range(0, 4095);
	endfunction

	function automatic void plan_item(ltbt_pkg::sensor_idx_t s, level_t lv, logic se);
		plan_row_t r;
		r = '0;
		r.s = s;
		r.lv = lv;
		r.se = se;
		plan_q.push_back(r);
	endfunction

	function automatic void plan_cfg(reg_idx_t ci, ltbt_pkg::tol_t cd);
		plan_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.ci = ci;
		r.cd = cd;
		plan_q.push_back(r);
	endfunction

	function automatic void plan_check(ltbt_pkg::sensor_idx_t s, level_t lv,
			ltbt_pkg::status_t hs, ltbt_pkg::status_t vs,
			ltbt_pkg::angle_t ha, ltbt_pkg::angle_t va, logic fnd);
		plan_row_t r;
		r = '0;
		r.s = s;
		r.lv = lv;
		r.se = 1'b1;
		r.typed = 1'b1;
		r.want.hs = hs;
		r.want.vs = vs;
		r.want.ha = ha;
		r.want.va = va;
		r.want.fnd = fnd;
		plan_q.push_back(r);
	endfunction

	initial begin
		#7200000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		int k;
		int n;
		int len;
		int base;
		int spread;
		int wild;
		int mode;
		int guard;
		int burst;
		bit last_cfg;

		// Fill every sensor before the first scan
		for (k = 0; k < 15; k++)
			plan_item(k[3:0], 12'd2000, 1'b0);
		plan_check(4'd15, 12'd2000, ltbt_pkg::ST_BALANCED, ltbt_pkg::ST_BALANCED,
			8'd90, 8'd90, 1'b1);
		plan_check(4'd6, 12'd4095, ltbt_pkg::ST_STEPPED, ltbt_pkg::ST_BALANCED,
			8'd91, 8'd90, 1'b0);
		plan_item(4'd6, 12'd0, 1'b1);
		plan_item(4'd2, 12'd0, 1'b1);
		// difference equal to the tolerance still counts as even light
		plan_item(4'd2, 12'd2205, 1'b1);
		plan_item(4'd2, 12'd2206, 1'b1);
		plan_cfg(ltbt_pkg::CFG_TOLERANCE, 12'd0);
		plan_item(4'd6, 12'd2000, 1'b1);
		plan_item(4'd2, 12'd2000, 1'b1);
		plan_cfg(ltbt_pkg::CFG_TOLERANCE, 12'd4095);
		plan_item(4'd14, 12'd0, 1'b1);
		// crossed limits hold every unbalanced axis
		plan_cfg(ltbt_pkg::CFG_TOLERANCE, 12'd0);
		plan_cfg(ltbt_pkg::CFG_UPPER_LIMIT, 12'd0);
		plan_cfg(ltbt_pkg::CFG_LOWER_LIMIT, 12'd180);
		plan_check(4'd12, 12'd4095, ltbt_pkg::ST_LIMIT, ltbt_pkg::ST_LIMIT,
			8'd87, 8'd89, 1'b1);
		// upper data bits of a limit write are dropped; index 3 is ignored
		plan_cfg(ltbt_pkg::CFG_UPPER_LIMIT, 12'hFFF);
		plan_cfg(ltbt_pkg::CFG_LOWER_LIMIT, 12'd0);
		plan_cfg(CFG_UNUSED, 12'hA5A);
		plan_item(4'd0, 12'd4095, 1'b1);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		last_cfg = 1'b0;
		foreach (plan_q[i]) begin
			if (plan_q[i].is_cfg) begin
				if (!last_cfg)
					settle();
				write_reg(plan_q[i].ci, plan_q[i].cd);
			end else
				send_sample(plan_q[i].s, plan_q[i].lv, plan_q[i].se, plan_q[i].typed,
					plan_q[i].want);
			last_cfg = plan_q[i].is_cfg;
		end

		n = 0;
		while (n < RANDOM_SAMPLES) begin
			settle();
			shuffle_config();
			no_gaps = ($urandom_range(0, 3) == 0);
			mode = $urandom_range(0, 2);
			spread = mode == 0 ? tol_r / 2 : mode == 1 ? tol_r + 1 : 2 * tol_r + 100;
			wild = mode == 0 ? 0 : 6;
			len = $urandom_range(30, 80);
			while (len > 0) begin
				k = $urandom_range(0, 9);
				if (k < 5) begin
					// full sweep, scan on the last sensor
					base = pick_base();
					for (int s = 0; s < 16; s++)
						send_sample(s[3:0], pick_level(base, spread, wild), s == 15, 1'b0, '0);
					len -= 16;
					n += 16;
				end else if (k < 9) begin
					// touch a few sensors, then scan
					base = stored_lvl[4'($urandom_range(0, 15))];
					burst = $urandom_range(1, 4);
					for (int j = burst; j > 0; j--)
						send_sample(4'($urandom_range(0, 15)), pick_level(base, spread, wild),
							j == 1, 1'b0, '0);
					len -= burst;
					n += burst;
				end else begin
					send_sample(4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)),
						1'($urandom_range(0, 1)), 1'b0, '0);
					len--;
					n++;
				end
			end
		end

		start <= 1'b0;
		guard = 0;
		while (due_q.size() != 0 && guard < 200) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (due_q.size() != 0) begin
			$display("%0d readings never arrived", due_q.size());
			mismatches += due_q.size();
		end

		$display("tracker: %0d samples taken, %0d scan readings checked, %0d register writes",
			samples_seen, readings_checked, reg_writes);
		$display("axis outcomes: %0d stepped, %0d balanced, %0d held at a limit; found %0d times",
			n_step, n_bal, n_lim, n_found);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
